/* hw/rtl/bsr_pkg.sv */
`default_nettype none

package bsr_pkg;

    // Width of the internal cubic evaluation (value, products, f)
    localparam int CALC_WIDTH   = 64;
    localparam int TOL_WIDTH    = 24;
    localparam int ITER_WIDTH   = 8;
    localparam int STATUS_WIDTH = 2;

    localparam logic [TOL_WIDTH-1:0]  TOL_RESET  = 24'd66;
    localparam logic [ITER_WIDTH-1:0] ITER_RESET = 8'd100;

    // Constant term of x^3 - 2x - 5
    localparam int CUBIC_OFFSET = 5;

    // Result status codes
    localparam logic [STATUS_WIDTH-1:0] STATUS_CONVERGED = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STATUS_LIMIT     = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STATUS_NO_CHANGE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_TOLERANCE = 1'b0;
    localparam logic CFG_MAX_ITER  = 1'b1;

    // Top-level sequencer
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EVAL_A = 6'b000010,
        S_EVAL_B = 6'b000100,
        S_MID    = 6'b001000,
        S_EVAL_C = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    // Cubic evaluator phases
    typedef enum logic [2:0] {
        E_IDLE = 3'b001,
        E_CUBE = 3'b010,
        E_SUB  = 3'b100
    } t_eval_state;

endpackage

`default_nettype wire

/* hw/rtl/bsr_cubic.sv */
`default_nettype none

// Evaluates f(x) = x^3 - 2x - 5 on one shared multiplier.
// start -> square -> cube -> subtract; done pulses with f valid after the subtract phase.
module bsr_cubic #(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 24
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_start,
    input  wire signed [VALUE_WIDTH-1:0]          i_x,
    output logic                                  o_done,
    output logic signed [bsr_pkg::CALC_WIDTH-1:0] o_f
);

    localparam int CW       = bsr_pkg::CALC_WIDTH;
    localparam int X2_FULL  = 2 * VALUE_WIDTH - FRAC_BITS;
    localparam int X2_CAPW  = CW - 1 - VALUE_WIDTH;
    localparam int X2_W     = (X2_FULL < X2_CAPW) ? X2_FULL : X2_CAPW;
    localparam int MUL_A_W  = (X2_W + 1 > VALUE_WIDTH) ? X2_W + 1 : VALUE_WIDTH;
    localparam int PROD_W   = MUL_A_W + VALUE_WIDTH;
    localparam logic [CW-1:0] X2_CAP = (CW'(1) << X2_CAPW) - CW'(1);
    localparam logic signed [CW-1:0] OFFSET = CW'(bsr_pkg::CUBIC_OFFSET) << FRAC_BITS;

    bsr_pkg::t_eval_state r_state, n_state;

    logic signed [VALUE_WIDTH-1:0] r_x;
    logic signed [CW-1:0]          r_prod;
    logic signed [CW-1:0]          r_f;
    logic                          r_done;

    logic [CW-1:0]                 x2_full;
    logic [X2_W-1:0]               x2;
    logic signed [MUL_A_W-1:0]     mul_a;
    logic signed [VALUE_WIDTH-1:0] mul_b;
    logic signed [PROD_W-1:0]      prod;
    logic signed [CW-1:0]          x3;
    logic signed [CW-1:0]          x_ext;

    // x^2 is nonnegative; clamp to the cap before the second multiply
    assign x2_full = $unsigned(r_prod) >> FRAC_BITS;
    assign x2      = (x2_full > X2_CAP) ? X2_W'(X2_CAP) : X2_W'(x2_full);

    // shared multiplier: x*x on start, x2*x in the cube phase
    always_comb begin
        if (r_state == bsr_pkg::E_CUBE) begin
            mul_a = $signed(MUL_A_W'(x2));
            mul_b = r_x;
        end else begin
            mul_a = MUL_A_W'(i_x);
            mul_b = i_x;
        end
    end

    assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign x3    = r_prod >>> FRAC_BITS;
    assign x_ext = CW'(r_x);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bsr_pkg::E_IDLE: if (i_start) n_state = bsr_pkg::E_CUBE;
            bsr_pkg::E_CUBE: n_state = bsr_pkg::E_SUB;
            bsr_pkg::E_SUB:  n_state = bsr_pkg::E_IDLE;
            default:         n_state = bsr_pkg::E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsr_pkg::E_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == bsr_pkg::E_SUB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bsr_pkg::E_IDLE && i_start) begin
            r_x    <= i_x;
            r_prod <= CW'(prod);
        end else if (r_state == bsr_pkg::E_CUBE) begin
            r_prod <= CW'(prod);
        end
        if (r_state == bsr_pkg::E_SUB) begin
            r_f <= x3 - (x_ext <<< 1) - OFFSET;   // x^3 - 2x - 5
        end
    end

    assign o_done = r_done;
    assign o_f    = r_f;

endmodule

`default_nettype wire

/* hw/rtl/bisection_root_finder.sv */
`default_nettype none

// Bisection root finder for f(x) = x^3 - 2x - 5. Each input beat carries a
// bracket [a, b] in signed fixed point (VALUE_WIDTH bits, FRAC_BITS fraction
// bits, Q8.16 by default). If f(a) and f(b) do not have strictly opposite
// signs the block returns root 0, status 2 (no sign change). Otherwise it
// bisects with c = (a+b)>>1 until |f(c)| < tolerance (status 0) or
// max_iterations steps are done (status 1); root is the last midpoint and
// iterations the number of completed steps. One result beat per input beat.
// The block takes one bracket at a time and holds s_tready low until
// its result beat has been taken. All cubic evaluations share one multiplier
// in a square/cube/subtract sequence; the two endpoint checks run one after
// the other, and each midpoint evaluation is a midpoint state followed by a
// cubic evaluation. Configuration: index 0 tolerance (24 bits, reset 66),
// index 1 max_iterations (8 bits, reset 100); cfg_ready is always high and
// writes are meant for idle periods only.
module bisection_root_finder #(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 24
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // slave stream: input brackets
    input  wire                    i_s_tvalid,
    output logic                   o_s_tready,
    input  wire  [((2 * VALUE_WIDTH + 7) / 8) * 8 - 1:0]
                                   i_s_tdata,   // lower_bound, upper_bound, zero pad
    // master stream: results
    output logic                   o_m_tvalid,
    input  wire                    i_m_tready,
    output logic [((VALUE_WIDTH + bsr_pkg::STATUS_WIDTH + bsr_pkg::ITER_WIDTH + 7) / 8) * 8 - 1:0]
                                   o_m_tdata,   // root, status, iterations, zero pad
    // configuration writes
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire                    i_cfg_index,
    input  wire  [bsr_pkg::TOL_WIDTH-1:0] i_cfg_data
);

    localparam int IN_RAW  = 2 * VALUE_WIDTH;
    localparam int IN_W    = ((IN_RAW + 7) / 8) * 8;
    localparam int OUT_RAW = VALUE_WIDTH + bsr_pkg::STATUS_WIDTH + bsr_pkg::ITER_WIDTH;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
    localparam int CW      = bsr_pkg::CALC_WIDTH;
    localparam int IW      = bsr_pkg::ITER_WIDTH;

    bsr_pkg::t_state r_state, n_state;

    // configuration registers
    logic [bsr_pkg::TOL_WIDTH-1:0] r_tolerance;
    logic [IW-1:0]                 r_max_iter;

    // bracket and progress
    logic signed [VALUE_WIDTH-1:0] r_a, r_b, r_c;
    logic                          r_fa_neg, r_fa_zero;
    logic [IW-1:0]                 r_iter;

    // result beat
    logic signed [VALUE_WIDTH-1:0]      r_root;
    logic [bsr_pkg::STATUS_WIDTH-1:0]   r_status;
    logic [IW-1:0]                      r_res_iter;

    logic                          in_beat;
    logic                          eval_start;
    logic signed [VALUE_WIDTH-1:0] eval_x;
    logic                          eval_done;
    logic signed [CW-1:0]          f;
    logic                          f_neg, f_pos;
    logic [CW-1:0]                 f_mag;
    logic                          conv;
    logic                          opposite;
    logic signed [VALUE_WIDTH:0]   sum;
    logic signed [VALUE_WIDTH-1:0] mid;
    logic [IW-1:0]                 iter_inc;

    assign in_beat     = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == bsr_pkg::S_IDLE);
    assign o_m_tvalid  = (r_state == bsr_pkg::S_OUT);
    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = OUT_W'({r_res_iter, r_status, r_root});

    // floor((a+b)/2) without overflow
    assign sum = (VALUE_WIDTH+1)'(r_a) + (VALUE_WIDTH+1)'(r_b);
    assign mid = sum[VALUE_WIDTH:1];

    assign f_neg    = f[CW-1];
    assign f_pos    = !f[CW-1] && (f != '0);
    assign f_mag    = f_neg ? $unsigned(-f) : $unsigned(f);
    assign conv     = f_mag < CW'(r_tolerance);
    // strict sign change between f(a) and the current f
    assign opposite = (r_fa_neg && f_pos) || (!r_fa_neg && !r_fa_zero && f_neg);
    assign iter_inc = r_iter + IW'(1);

    // one evaluation at a time: a on accept, b after a, c from the midpoint state
    always_comb begin
        eval_start = 1'b0;
        eval_x     = mid;
        if (in_beat) begin
            eval_start = 1'b1;
            eval_x     = $signed(i_s_tdata[VALUE_WIDTH-1:0]);
        end else if (r_state == bsr_pkg::S_EVAL_A && eval_done) begin
            eval_start = 1'b1;
            eval_x     = r_b;
        end else if (r_state == bsr_pkg::S_MID) begin
            eval_start = 1'b1;
            eval_x     = mid;
        end
    end

    bsr_cubic #(
        .FRAC_BITS   (FRAC_BITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cubic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (eval_start),
        .i_x     (eval_x),
        .o_done  (eval_done),
        .o_f     (f)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bsr_pkg::S_IDLE: begin
                if (in_beat) n_state = bsr_pkg::S_EVAL_A;
            end
            bsr_pkg::S_EVAL_A: begin
                if (eval_done) n_state = bsr_pkg::S_EVAL_B;
            end
            bsr_pkg::S_EVAL_B: begin
                if (eval_done) begin
                    if (!opposite || r_max_iter == '0) n_state = bsr_pkg::S_OUT;
                    else                               n_state = bsr_pkg::S_MID;
                end
            end
            bsr_pkg::S_MID: begin
                n_state = bsr_pkg::S_EVAL_C;
            end
            bsr_pkg::S_EVAL_C: begin
                if (eval_done) begin
                    if (conv || iter_inc == r_max_iter) n_state = bsr_pkg::S_OUT;
                    else                                n_state = bsr_pkg::S_MID;
                end
            end
            bsr_pkg::S_OUT: begin
                if (i_m_tready) n_state = bsr_pkg::S_IDLE;
            end
            default: n_state = bsr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bsr_pkg::S_IDLE;
            r_tolerance <= bsr_pkg::TOL_RESET;
            r_max_iter  <= bsr_pkg::ITER_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    bsr_pkg::CFG_TOLERANCE: r_tolerance <= i_cfg_data;
                    bsr_pkg::CFG_MAX_ITER:  r_max_iter  <= i_cfg_data[IW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            bsr_pkg::S_IDLE: begin
                if (in_beat) begin
                    r_a    <= $signed(i_s_tdata[VALUE_WIDTH-1:0]);
                    r_b    <= $signed(i_s_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]);
                    r_iter <= '0;
                end
            end
            bsr_pkg::S_EVAL_A: begin
                if (eval_done) begin
                    r_fa_neg  <= f_neg;
                    r_fa_zero <= (f == '0);
                end
            end
            bsr_pkg::S_EVAL_B: begin
                if (eval_done) begin
                    r_res_iter <= '0;
                    if (!opposite) begin
                        r_root   <= '0;
                        r_status <= bsr_pkg::STATUS_NO_CHANGE;
                    end else begin
                        // zero step limit: report the first midpoint unevaluated
                        r_root   <= mid;
                        r_status <= bsr_pkg::STATUS_LIMIT;
                    end
                end
            end
            bsr_pkg::S_MID: begin
                r_c <= mid;
            end
            bsr_pkg::S_EVAL_C: begin
                if (eval_done) begin
                    r_root <= r_c;
                    if (conv) begin
                        r_status   <= bsr_pkg::STATUS_CONVERGED;
                        r_res_iter <= r_iter;
                    end else begin
                        r_status   <= bsr_pkg::STATUS_LIMIT;
                        r_res_iter <= iter_inc;
                        r_iter     <= iter_inc;
                        if (opposite) begin
                            r_b <= r_c;
                        end else begin
                            r_a       <= r_c;
                            r_fa_neg  <= f_neg;
                            r_fa_zero <= (f == '0);
                        end
                    end
                end
            end
            bsr_pkg::S_OUT: ;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/bsr_checker.sv */
`default_nettype none

module bsr_checker #(
    parameter int VALUE_WIDTH = 24,
    parameter int OUT_W       = 40
) (
    input wire                    i_clk,
    input wire                    i_rst_n,
    input wire                    i_s_tvalid,
    input wire                    o_s_tready,
    input wire                    o_m_tvalid,
    input wire                    i_m_tready,
    input wire [OUT_W-1:0]        o_m_tdata
);

    localparam int SL = VALUE_WIDTH;
    localparam int IL = VALUE_WIDTH + bsr_pkg::STATUS_WIDTH;

    // one bracket at a time: no input taken while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while result pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready && !o_m_tvalid)
        else $error("block not busy after accepting a bracket");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[IL-1:SL] == bsr_pkg::STATUS_CONVERGED ||
                        o_m_tdata[IL-1:SL] == bsr_pkg::STATUS_LIMIT ||
                        o_m_tdata[IL-1:SL] == bsr_pkg::STATUS_NO_CHANGE))
        else $error("undefined status code");

    a_no_change_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[IL-1:SL] == bsr_pkg::STATUS_NO_CHANGE) |->
            (o_m_tdata[OUT_W-1:IL] == '0 && o_m_tdata[SL-1:0] == '0))
        else $error("no-sign-change result carries nonzero root or count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result beat changed");

endmodule

bind bisection_root_finder bsr_checker #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .OUT_W       (OUT_W)
) u_bsr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata)
);

`default_nettype wire
